[rtl/mmie_pkg.sv]
// ----------------------------------------------------------------------------
// Mini-MIPS executor package
// Shared widths, instruction codes and the status group that the execute
// unit hands to the top level.
// ----------------------------------------------------------------------------
package mmie_pkg;

  localparam int unsigned DATA_WORDS_DEF = 64;
  localparam int unsigned WORD_WIDTH_DEF = 32;
  localparam int unsigned REG_COUNT      = 8;

  localparam int unsigned INSTR_W    = 16;
  localparam int unsigned PC_W       = 8;
  localparam int unsigned PLEN_W     = 9;
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned IMM_W      = 6;
  localparam int unsigned JADDR_W    = 7;
  localparam int unsigned OUT_WORD_W = 32;

  typedef enum logic [3:0] {
    OP_RTYPE = 4'd0,
    OP_JUMP  = 4'd2,
    OP_ADDI  = 4'd4,
    OP_BEQ   = 4'd8,
    OP_LW    = 4'd11,
    OP_SW    = 4'd15
  } opcode_e;

  typedef enum logic [2:0] {
    FN_ADD = 3'd0,
    FN_SUB = 3'd2,
    FN_AND = 3'd4,
    FN_OR  = 3'd5
  } funct_e;

  // Where a registered read takes its operand from.
  typedef enum logic [1:0] {
    SRC_ZERO = 2'd0,
    SRC_MEM  = 2'd1,
    SRC_FWD  = 2'd2
  } rd_src_e;

  typedef struct packed {
    logic reg_we;
    logic mem_we;
    logic taken;
    logic unknown;
  } exec_flags_t;

endpackage

[rtl/mmie_exec.sv]
// ----------------------------------------------------------------------------
// Mini-MIPS execute unit
// Decodes one instruction and computes its register write, store, next
// program counter and status flags from the operands already read.
// ----------------------------------------------------------------------------
module mmie_exec
  import mmie_pkg::*;
#(
  parameter int unsigned WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic [INSTR_W-1:0]    instr_i,
  input  logic [PC_W-1:0]       pc_i,
  input  logic [PLEN_W-1:0]     plen_i,
  input  logic [WORD_WIDTH-1:0] op_a_i,
  input  logic [WORD_WIDTH-1:0] op_b_i,
  input  logic [WORD_WIDTH-1:0] load_i,
  output exec_flags_t           flags_o,
  output logic [PC_W-1:0]       next_pc_o,
  output logic [REG_IDX_W-1:0]  reg_idx_o,
  output logic [WORD_WIDTH-1:0] reg_val_o,
  output logic [IMM_W-1:0]      mem_addr_o,
  output logic [WORD_WIDTH-1:0] mem_val_o
);

  logic [3:0]           opcode;
  logic [REG_IDX_W-1:0] rt;
  logic [REG_IDX_W-1:0] rd;
  logic [2:0]           funct;
  logic [IMM_W-1:0]     imm;
  logic [JADDR_W-1:0]   jaddr;
  logic                 is_branch;
  logic [PC_W-1:0]      pc_inc;

  assign opcode = instr_i[15:12];
  assign rt     = instr_i[8:6];
  assign rd     = instr_i[5:3];
  assign funct  = instr_i[2:0];
  assign imm    = instr_i[IMM_W-1:0];
  assign jaddr  = instr_i[JADDR_W-1:0];
  assign pc_inc = pc_i + PC_W'(1);

  always_comb begin
    flags_o    = '0;
    is_branch  = 1'b0;
    next_pc_o  = pc_i;
    reg_idx_o  = '0;
    reg_val_o  = '0;
    mem_addr_o = '0;
    mem_val_o  = '0;
    case (opcode)
      OP_RTYPE: begin
        reg_idx_o      = rd;
        flags_o.reg_we = 1'b1;
        case (funct)
          FN_ADD: reg_val_o = op_a_i + op_b_i;
          FN_SUB: reg_val_o = op_a_i - op_b_i;
          FN_AND: reg_val_o = op_a_i & op_b_i;
          FN_OR:  reg_val_o = op_a_i | op_b_i;
          default: begin
            reg_idx_o       = '0;
            flags_o.reg_we  = 1'b0;
            flags_o.unknown = 1'b1;
          end
        endcase
      end
      OP_ADDI: begin
        flags_o.reg_we = 1'b1;
        reg_idx_o      = rt;
        reg_val_o      = op_a_i + WORD_WIDTH'(imm);
      end
      OP_LW: begin
        // With the default store of 64 words every immediate hits.
        flags_o.reg_we = 1'b1;
        reg_idx_o      = rt;
        reg_val_o      = load_i;
      end
      OP_SW: begin
        flags_o.mem_we = 1'b1;
        mem_addr_o     = imm;
        mem_val_o      = op_b_i;
      end
      OP_BEQ: begin
        is_branch = 1'b1;
        if (op_a_i == op_b_i) begin
          flags_o.taken = 1'b1;
          next_pc_o     = pc_i + PC_W'(imm) + PC_W'(1);
        end else begin
          next_pc_o = pc_inc;
        end
      end
      OP_JUMP: begin
        is_branch     = 1'b1;
        flags_o.taken = 1'b1;
        next_pc_o     = PC_W'(jaddr);
      end
      default: begin
        flags_o.unknown = 1'b1;
      end
    endcase
    // Past the end of the program the counter parks on non-branch words.
    if (!is_branch) begin
      next_pc_o = ({1'b0, pc_i} < plen_i) ? pc_inc : pc_i;
    end
  end

endmodule

[rtl/mini_mips_instruction_executor.sv]
// ----------------------------------------------------------------------------
// Mini-MIPS instruction executor
// Executes one 16-bit instruction per word against eight registers and a
// zero-initialized data store, and reports every effect of the word.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake               | Payload
//  ---------+-----------+-------------------------+--------------------------
//  in       | input     | in_valid_i / in_ready_o | instruction_word_i
//  out      | output    | out_valid_o/ out_ready_i| next_pc_o .. unknown_instruction_o
//  cfg      | input     | cfg_we_i (no wait)      | cfg_wdata_i (program length)
//
// One word per cycle is sustained while the output is not stalled. The
// register file and data store are read into registers when a word is
// accepted; the word then executes from the execute register, writing state
// and the result register when it leaves that stage.
// A stalled output holds the executing word and drops in_ready_o.
// Reset clears the pc, program length and the valid bits that make unwritten
// registers and store words read as zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
module mini_mips_instruction_executor
  import mmie_pkg::*;
#(
  parameter int unsigned DATA_WORDS = DATA_WORDS_DEF,
  parameter int unsigned WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [PLEN_W-1:0]            cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [INSTR_W-1:0]           instruction_word_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [PC_W-1:0]              next_pc_o,
  output logic                         reg_write_done_o,
  output logic [REG_IDX_W-1:0]         reg_write_index_o,
  output logic signed [OUT_WORD_W-1:0] reg_write_value_o,
  output logic                         mem_write_done_o,
  output logic [IMM_W-1:0]             mem_write_address_o,
  output logic signed [OUT_WORD_W-1:0] mem_write_value_o,
  output logic                         branch_taken_o,
  output logic                         unknown_instruction_o
);

  localparam int unsigned DAW = $clog2(DATA_WORDS);

  // Handshake and pipeline control.
  logic                 accept;
  logic                 advance;
  logic                 e_fire;
  logic                 e_valid_q;
  logic [INSTR_W-1:0]   e_instr_q;
  logic                 out_valid_q;
  logic [PC_W-1:0]      pc_q;
  logic [PLEN_W-1:0]    plen_q;

  // Register file and data store.
  logic [WORD_WIDTH-1:0] rf_mem [REG_COUNT];
  logic [REG_COUNT-1:0]  rf_vld_q;
  logic [WORD_WIDTH-1:0] dm_mem [DATA_WORDS];
  logic [DATA_WORDS-1:0] dm_vld_q;

  logic [REG_IDX_W-1:0]  rf_ra;
  logic [REG_IDX_W-1:0]  rf_rb;
  logic [DAW-1:0]        dm_ra;
  logic                  rf_we;
  logic                  dm_we;
  logic [DAW-1:0]        dm_waddr;

  logic [WORD_WIDTH-1:0] rfa_mem_q;
  logic [WORD_WIDTH-1:0] rfb_mem_q;
  logic [WORD_WIDTH-1:0] dm_mem_q;
  logic [WORD_WIDTH-1:0] rf_fwd_q;
  logic [WORD_WIDTH-1:0] dm_fwd_q;
  rd_src_e               rfa_src_q;
  rd_src_e               rfb_src_q;
  rd_src_e               dm_src_q;

  logic [WORD_WIDTH-1:0] op_a;
  logic [WORD_WIDTH-1:0] op_b;
  logic [WORD_WIDTH-1:0] load_val;

  // Execute unit results.
  exec_flags_t           ex_flags;
  logic [PC_W-1:0]       ex_next_pc;
  logic [REG_IDX_W-1:0]  ex_reg_idx;
  logic [WORD_WIDTH-1:0] ex_reg_val;
  logic [IMM_W-1:0]      ex_mem_addr;
  logic [WORD_WIDTH-1:0] ex_mem_val;

  assign advance    = !out_valid_q || out_ready_i;
  assign e_fire     = e_valid_q && advance;
  assign in_ready_o = !e_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  assign rf_ra    = instruction_word_i[11:9];
  assign rf_rb    = instruction_word_i[8:6];
  assign dm_ra    = DAW'(instruction_word_i[IMM_W-1:0]);
  assign rf_we    = e_fire && ex_flags.reg_we;
  assign dm_we    = e_fire && ex_flags.mem_we;
  assign dm_waddr = DAW'(ex_mem_addr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= '0;
      plen_q      <= '0;
      rf_vld_q    <= '0;
      dm_vld_q    <= '0;
    end else begin
      if (accept) begin
        e_valid_q <= 1'b1;
      end else if (e_fire) begin
        e_valid_q <= 1'b0;
      end
      if (e_fire) begin
        out_valid_q <= 1'b1;
        pc_q        <= ex_next_pc;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        plen_q <= cfg_wdata_i;
      end
      if (rf_we) begin
        rf_vld_q[ex_reg_idx] <= 1'b1;
      end
      if (dm_we) begin
        dm_vld_q[dm_waddr] <= 1'b1;
      end
    end
  end

  // Storage arrays with registered reads. A write landing at the same edge
  // as a read of the same entry is forwarded instead of read.
  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[ex_reg_idx] <= ex_reg_val;
    end
    if (dm_we) begin
      dm_mem[dm_waddr] <= ex_mem_val;
    end
    if (accept) begin
      e_instr_q <= instruction_word_i;
      rfa_mem_q <= rf_mem[rf_ra];
      rfb_mem_q <= rf_mem[rf_rb];
      dm_mem_q  <= dm_mem[dm_ra];
      rf_fwd_q  <= ex_reg_val;
      dm_fwd_q  <= ex_mem_val;
      rfa_src_q <= (rf_we && ex_reg_idx == rf_ra) ? SRC_FWD :
                   rf_vld_q[rf_ra] ? SRC_MEM : SRC_ZERO;
      rfb_src_q <= (rf_we && ex_reg_idx == rf_rb) ? SRC_FWD :
                   rf_vld_q[rf_rb] ? SRC_MEM : SRC_ZERO;
      dm_src_q  <= (dm_we && dm_waddr == dm_ra) ? SRC_FWD :
                   dm_vld_q[dm_ra] ? SRC_MEM : SRC_ZERO;
    end
  end

  always_comb begin
    case (rfa_src_q)
      SRC_MEM: op_a = rfa_mem_q;
      SRC_FWD: op_a = rf_fwd_q;
      default: op_a = '0;
    endcase
    case (rfb_src_q)
      SRC_MEM: op_b = rfb_mem_q;
      SRC_FWD: op_b = rf_fwd_q;
      default: op_b = '0;
    endcase
    case (dm_src_q)
      SRC_MEM: load_val = dm_mem_q;
      SRC_FWD: load_val = dm_fwd_q;
      default: load_val = '0;
    endcase
  end

  mmie_exec #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_exec (
    .instr_i    (e_instr_q),
    .pc_i       (pc_q),
    .plen_i     (plen_q),
    .op_a_i     (op_a),
    .op_b_i     (op_b),
    .load_i     (load_val),
    .flags_o    (ex_flags),
    .next_pc_o  (ex_next_pc),
    .reg_idx_o  (ex_reg_idx),
    .reg_val_o  (ex_reg_val),
    .mem_addr_o (ex_mem_addr),
    .mem_val_o  (ex_mem_val)
  );

  // Result register.
  always_ff @(posedge clk_i) begin
    if (e_fire) begin
      next_pc_o             <= ex_next_pc;
      reg_write_done_o      <= ex_flags.reg_we;
      reg_write_index_o     <= ex_reg_idx;
      reg_write_value_o     <= OUT_WORD_W'(signed'(ex_reg_val));
      mem_write_done_o      <= ex_flags.mem_we;
      mem_write_address_o   <= ex_mem_addr;
      mem_write_value_o     <= OUT_WORD_W'(signed'(ex_mem_val));
      branch_taken_o        <= ex_flags.taken;
      unknown_instruction_o <= ex_flags.unknown;
    end
  end

  assign out_valid_o = out_valid_q;

  // An executing word always leaves a result behind it.
  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_fire |=> out_valid_q)
    else $error("executed word produced no result");

  // A stalled result holds the executing word, so nothing new may enter.
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (e_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("word accepted while the execute stage was stalled");

  // A taken result drained with nothing behind it leaves the output empty.
  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ready_i && !e_fire) |=> !out_valid_q)
    else $error("result repeated after it was taken");

  // An unrecognized word has no side effects.
  a_unknown_no_effect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (e_fire && ex_flags.unknown) |->
      (!ex_flags.reg_we && !ex_flags.mem_we && !ex_flags.taken))
    else $error("unrecognized word changed state");

  // The pc only moves when a word executes.
  a_pc_moves_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !e_fire |=> $stable(pc_q))
    else $error("pc changed without an executing word");

endmodule

[tb/mini_mips_instruction_executor_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mini-MIPS instruction executor testbench
// Feeds directed and random instruction words through the valid/ready input,
// predicts every result with a private copy of the pc, registers and data
// store, and checks each result word field by field under varied idling,
// program lengths and long output hold-offs.
// ----------------------------------------------------------------------------
module mini_mips_instruction_executor_test;
  import mmie_pkg::*;

  typedef struct packed {
    logic [7:0]  next_pc;
    logic        reg_we;
    logic [2:0]  reg_idx;
    logic [31:0] reg_val;
    logic        mem_we;
    logic [5:0]  mem_addr;
    logic [31:0] mem_val;
    logic        taken;
    logic        unknown;
  } exec_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [8:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] instruction_word_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  next_pc_o;
  logic        reg_write_done_o;
  logic [2:0]  reg_write_index_o;
  logic signed [31:0] reg_write_value_o;
  logic        mem_write_done_o;
  logic [5:0]  mem_write_address_o;
  logic signed [31:0] mem_write_value_o;
  logic        branch_taken_o;
  logic        unknown_instruction_o;

  // Predicted machine state.
  logic [31:0] gpr_model [8] = '{default: '0};
  logic [31:0] store_model [64] = '{default: '0};
  logic [7:0]  pc_model = '0;
  logic [8:0]  plen_model = '0;

  logic [15:0]  word_queue [$];
  exec_result_t pending_results [$];
  int unsigned  error_count = 0;
  int unsigned  sender_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  bit           hold_en = 1'b0;
  bit           hold_done;
  int unsigned  hold_left;

  mini_mips_instruction_executor dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .instruction_word_i    (instruction_word_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .next_pc_o             (next_pc_o),
    .reg_write_done_o      (reg_write_done_o),
    .reg_write_index_o     (reg_write_index_o),
    .reg_write_value_o     (reg_write_value_o),
    .mem_write_done_o      (mem_write_done_o),
    .mem_write_address_o   (mem_write_address_o),
    .mem_write_value_o     (mem_write_value_o),
    .branch_taken_o        (branch_taken_o),
    .unknown_instruction_o (unknown_instruction_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Executes one word against the predicted state and returns its result.
  function automatic exec_result_t execute_word(input logic [15:0] w);
    exec_result_t r;
    logic [31:0]  a;
    logic [31:0]  b;
    logic         branch;
    logic [5:0]   imm;
    r      = '0;
    branch = 1'b0;
    imm    = w[5:0];
    a      = gpr_model[w[11:9]];
    b      = gpr_model[w[8:6]];
    case (w[15:12])
      OP_RTYPE: begin
        r.reg_we  = 1'b1;
        r.reg_idx = w[5:3];
        case (w[2:0])
          FN_ADD: r.reg_val = a + b;
          FN_SUB: r.reg_val = a - b;
          FN_AND: r.reg_val = a & b;
          FN_OR:  r.reg_val = a | b;
          default: begin
            r.reg_we  = 1'b0;
            r.reg_idx = '0;
            r.unknown = 1'b1;
          end
        endcase
      end
      OP_ADDI: begin
        r.reg_we  = 1'b1;
        r.reg_idx = w[8:6];
        r.reg_val = a + {26'b0, imm};
      end
      OP_LW: begin
        r.reg_we  = 1'b1;
        r.reg_idx = w[8:6];
        r.reg_val = store_model[imm];
      end
      OP_SW: begin
        r.mem_we   = 1'b1;
        r.mem_addr = imm;
        r.mem_val  = b;
        store_model[imm] = b;
      end
      OP_BEQ: begin
        branch = 1'b1;
        if (a == b) begin
          r.taken   = 1'b1;
          r.next_pc = pc_model + {2'b0, imm} + 8'd1;
        end else begin
          r.next_pc = pc_model + 8'd1;
        end
      end
      OP_JUMP: begin
        branch    = 1'b1;
        r.taken   = 1'b1;
        r.next_pc = {1'b0, w[6:0]};
      end
      default: r.unknown = 1'b1;
    endcase
    if (r.reg_we) gpr_model[r.reg_idx] = r.reg_val;
    // Past the end of the program the pc holds on anything but a branch.
    if (!branch) r.next_pc = ({1'b0, pc_model} < plen_model) ? pc_model + 8'd1 : pc_model;
    pc_model = r.next_pc;
    return r;
  endfunction

  function automatic logic [15:0] enc_r(input int rs, input int rt, input int rd,
                                        input logic [2:0] fn);
    return {OP_RTYPE, rs[2:0], rt[2:0], rd[2:0], fn};
  endfunction

  function automatic logic [15:0] enc_i(input logic [3:0] op, input int rs, input int rt,
                                        input int imm);
    return {op, rs[2:0], rt[2:0], imm[5:0]};
  endfunction

  function automatic logic [15:0] enc_j(input int addr);
    return {OP_JUMP, 5'b0, addr[6:0]};
  endfunction

  // Mostly well-formed words with random fields, plus bad functs, unknown
  // opcodes and raw noise.
  function automatic logic [15:0] rand_word();
    logic [15:0] w;
    int unsigned pick;
    w    = 16'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      w[15:12] = OP_RTYPE;
      case ($urandom_range(0, 3))
        0: w[2:0] = FN_ADD;
        1: w[2:0] = FN_SUB;
        2: w[2:0] = FN_AND;
        default: w[2:0] = FN_OR;
      endcase
    end else if (pick < 45) begin
      w[15:12] = OP_ADDI;
    end else if (pick < 58) begin
      w[15:12] = OP_LW;
    end else if (pick < 71) begin
      w[15:12] = OP_SW;
    end else if (pick < 81) begin
      w[15:12] = OP_BEQ;
      if (pick < 76) w[8:6] = w[11:9];
    end else if (pick < 87) begin
      w[15:12] = OP_JUMP;
    end else if (pick < 92) begin
      w[15:12] = OP_RTYPE;
      w[2:0]   = $urandom_range(0, 1) ? {2'b11, w[0]} : {1'b0, w[1], 1'b1};
    end else if (pick < 96) begin
      do w[15:12] = 4'($urandom_range(0, 15));
      while (w[15:12] inside {OP_RTYPE, OP_JUMP, OP_ADDI, OP_BEQ, OP_LW, OP_SW});
    end
    return w;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  // Sender: a word stays on the bus until it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) pending_results.push_back(execute_word(instruction_word_i));
      if (!in_valid_i || in_ready_o) begin
        if (word_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          in_valid_i         <= 1'b1;
          instruction_word_i <= word_queue.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, and in the pressure phase long hold-offs.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_en && (!hold_done || $urandom_range(0, 149) == 0)) begin
      out_ready_i <= 1'b0;
      hold_left   <= 63;
      hold_done   <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    exec_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result word with no expectation pending, next_pc 0x%0h", next_pc_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("next_pc", want.next_pc, next_pc_o);
        check_field("reg_write_done", want.reg_we, reg_write_done_o);
        check_field("reg_write_index", want.reg_idx, reg_write_index_o);
        check_field("reg_write_value", want.reg_val, reg_write_value_o);
        check_field("mem_write_done", want.mem_we, mem_write_done_o);
        check_field("mem_write_address", want.mem_addr, mem_write_address_o);
        check_field("mem_write_value", want.mem_val, mem_write_value_o);
        check_field("branch_taken", want.taken, branch_taken_o);
        check_field("unknown_instruction", want.unknown, unknown_instruction_o);
      end
    end
  end

  task automatic wait_idle();
    while (word_queue.size() != 0 || in_valid_i || pending_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [8:0] plen, input int n, input int snd_idle,
                           input int rcv_stall, input bit pressure);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= plen;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    plen_model      = plen;
    sender_idle_pct = snd_idle;
    recv_stall_pct  = rcv_stall;
    hold_en         = pressure;
    for (int k = 0; k < n; k++) word_queue.push_back(rand_word());
    wait_idle();
    hold_en = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words run with the reset program length of zero, so the pc
    // only moves on branches and jumps.
    word_queue.push_back(enc_i(OP_ADDI, 0, 1, 63));
    word_queue.push_back(enc_r(0, 1, 2, FN_SUB));
    word_queue.push_back(enc_r(2, 1, 3, FN_ADD));
    word_queue.push_back(enc_r(2, 1, 4, FN_AND));
    word_queue.push_back(enc_r(2, 1, 5, FN_OR));
    word_queue.push_back(enc_r(5, 5, 6, FN_ADD));
    word_queue.push_back(enc_i(OP_SW, 7, 2, 63));
    word_queue.push_back(enc_i(OP_SW, 0, 5, 0));
    word_queue.push_back(enc_i(OP_LW, 3, 7, 63));
    word_queue.push_back(enc_i(OP_LW, 0, 6, 17));
    word_queue.push_back(enc_i(OP_ADDI, 1, 0, 5));
    word_queue.push_back(enc_r(1, 2, 3, 3'd1));
    word_queue.push_back(enc_r(3, 4, 5, 3'd3));
    word_queue.push_back(enc_r(5, 6, 7, 3'd6));
    word_queue.push_back(enc_r(7, 0, 1, 3'd7));
    word_queue.push_back(16'hFFFF);
    word_queue.push_back(16'h0000);
    word_queue.push_back({4'd1, 12'hABC});
    word_queue.push_back({4'd12, 12'h5A5});
    word_queue.push_back(enc_j(127));
    word_queue.push_back(enc_i(OP_BEQ, 0, 0, 63));
    word_queue.push_back(enc_i(OP_BEQ, 3, 4, 63));
    // Taken branch from pc 192 wraps past 255.
    word_queue.push_back(enc_i(OP_BEQ, 5, 5, 63));
    word_queue.push_back(enc_j(0));
    word_queue.push_back(enc_i(OP_BEQ, 1, 2, 9));
    wait_idle();

    run_phase(9'd256, 300, 0, 0, 1'b0);
    run_phase(9'd255, 300, 50, 0, 1'b0);
    run_phase(9'($urandom_range(1, 254)), 300, 0, 50, 1'b0);
    run_phase(9'd0, 300, 9, 9, 1'b0);
    run_phase(9'd1, 300, 0, 0, 1'b1);
    run_phase(9'($urandom_range(2, 254)), 300, 9, 9, 1'b0);

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
